/* design/rotation_matrix_to_euler_angles_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to Euler angles core
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RMEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds at every edge
`define RMEA_ASSERT_ALWAYS(lbl, cond, msg) \
  `RMEA_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

/* design/rmea_pkg.sv */
// ----------------------------------------------------------------------------
// rmea_pkg
// Types and constants shared by the Euler angle core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rmea_pkg;

  localparam int SQ_STAGES = 19;   // one root bit per cell
  localparam int CO_STAGES = 16;   // CORDIC vectoring iterations

  // atan(2^-i) in 1/65536 degree
  localparam logic [21:0] ATAN_TAB [CO_STAGES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117305,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [20:0] rem;
    logic [18:0] root;
    logic [37:0] rad;
  } sq_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
    logic               zero;
  } lane_t;

endpackage

`default_nettype wire

/* design/rmea_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmea_sqrt_cell
// One digit step of the square root recurrence, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rmea_sqrt_cell (
  input  wire logic         clk,
  input  wire rmea_pkg::sq_t d,
  output rmea_pkg::sq_t      q_r
);
  import rmea_pkg::*;

  logic [22:0] rem2;
  logic [22:0] trial;
  logic        ge;
  sq_t         q_nxt;

  always_comb begin
    rem2       = {d.rem, d.rad[37:36]};
    trial      = {2'b00, d.root, 2'b01};
    ge         = (rem2 >= trial);
    q_nxt.rem  = ge ? 21'(rem2 - trial) : rem2[20:0];
    q_nxt.root = {d.root[17:0], ge};
    q_nxt.rad  = {d.rad[35:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

`default_nettype wire

/* design/rmea_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rmea_cordic_cell
// One CORDIC vectoring iteration, registered; stage sets shift and angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmea_cordic_cell (
  input  wire logic           clk,
  input  wire logic [3:0]     stage,
  input  wire rmea_pkg::lane_t d,
  output rmea_pkg::lane_t      q_r
);
  import rmea_pkg::*;

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [25:0] t;
  lane_t              q_nxt;

  always_comb begin
    dx         = d.x >>> stage;
    dy         = d.y >>> stage;
    t          = signed'({4'b0000, ATAN_TAB[stage]});
    q_nxt.zero = d.zero;
    if (d.y < 0) begin
      q_nxt.x = d.x - dy;
      q_nxt.y = d.y + dx;
      q_nxt.z = d.z - t;
    end else begin
      q_nxt.x = d.x + dy;
      q_nxt.y = d.y - dx;
      q_nxt.z = d.z + t;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

`default_nettype wire

/* design/rotation_matrix_to_euler_angles_core.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core
// Rotation matrix (Q1.14) to Euler angles (1/128 deg) for six axis orders.
// ----------------------------------------------------------------------------
// out_valid follows start through the input register, the valid chain and the output register.
// Throughput: one beat per cycle; busy is always low, every cell row advances
//   each cycle (19 root cells, then 16 CORDIC cells on three lanes).
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) clears the valid chain and loads
//   limit_r with 16384; data registers are not reset.
`default_nettype none

module rotation_matrix_to_euler_angles_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [15:0] in_r11,
  input  wire logic signed [15:0] in_r12,
  input  wire logic signed [15:0] in_r13,
  input  wire logic signed [15:0] in_r21,
  input  wire logic signed [15:0] in_r22,
  input  wire logic signed [15:0] in_r23,
  input  wire logic signed [15:0] in_r31,
  input  wire logic signed [15:0] in_r32,
  input  wire logic signed [15:0] in_r33,
  input  wire logic [2:0]         in_order_code,
  input  wire logic               cfg_we,
  input  wire logic [14:0]        cfg_wdata,
  output      logic               out_valid,
  output      logic signed [15:0] out_angle_x,
  output      logic signed [15:0] out_angle_y,
  output      logic signed [15:0] out_angle_z,
  output      logic               out_bad_order
);
  import rmea_pkg::*;

`include "rotation_matrix_to_euler_angles_core_defines.svh"

  localparam int VLD_LEN = SQ_STAGES + CO_STAGES + 1;

  // side data riding along the root cells
  typedef struct packed {
    lane_t              lo;
    lane_t              hi;
    logic signed [15:0] p;
    logic [1:0]         axis;
    logic               bad;
  } side_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       bad;
  } meta_t;

  // ---- configuration ----
  logic [14:0] limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 15'd16384;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // ---- input beat register ----
  logic               in_vld_r;
  logic signed [15:0] m_r [9];
  logic [2:0]         code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      m_r[0] <= in_r11; m_r[1] <= in_r12; m_r[2] <= in_r13;
      m_r[3] <= in_r21; m_r[4] <= in_r22; m_r[5] <= in_r23;
      m_r[6] <= in_r31; m_r[7] <= in_r32; m_r[8] <= in_r33;
      code_r <= in_order_code;
    end
  end

  // atan2 operand set-up: zero test, quadrant fold, scale by 4096
  function automatic lane_t prerot(input logic signed [16:0] yy,
                                   input logic signed [16:0] xx);
    lane_t              l;
    logic signed [33:0] x34;
    logic signed [33:0] y34;
    begin
      x34    = 34'(xx);
      y34    = 34'(yy);
      l.zero = (xx == 17'sd0) && (yy == 17'sd0);
      l.z    = 26'sd0;
      if (xx < 0) begin
        if (yy >= 0) begin
          l.x = y34 <<< 12;
          l.y = (-x34) <<< 12;
          l.z = 26'sd5898240;
        end else begin
          l.x = (-y34) <<< 12;
          l.y = x34 <<< 12;
          l.z = -26'sd5898240;
        end
      end else begin
        l.x = x34 <<< 12;
        l.y = y34 <<< 12;
      end
      prerot = l;
    end
  endfunction

  // ---- order decode: pivot, asin argument, lane operands ----
  logic signed [16:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  logic signed [16:0] piv, aarg, zz;
  logic [16:0]        piv_abs;
  logic               reg_br;
  logic signed [15:0] p_cl;
  logic [28:0]        pp;
  side_t              side_nxt;
  sq_t                sq_nxt;

  always_comb begin
    e11 = 17'(m_r[0]); e12 = 17'(m_r[1]); e13 = 17'(m_r[2]);
    e21 = 17'(m_r[3]); e22 = 17'(m_r[4]); e23 = 17'(m_r[5]);
    e31 = 17'(m_r[6]); e32 = 17'(m_r[7]); e33 = 17'(m_r[8]);
    zz  = 17'sd0;
    side_nxt.bad = 1'b0;
    unique case (code_r)
      3'd0: begin piv = e13; aarg = e13;  side_nxt.axis = AX_Y; end
      3'd1: begin piv = e21; aarg = e21;  side_nxt.axis = AX_Z; end
      3'd2: begin piv = e32; aarg = e32;  side_nxt.axis = AX_X; end
      3'd3: begin piv = e12; aarg = -e12; side_nxt.axis = AX_Z; end
      3'd4: begin piv = e23; aarg = -e23; side_nxt.axis = AX_X; end
      3'd5: begin piv = e31; aarg = -e31; side_nxt.axis = AX_Y; end
      default: begin
        piv = zz; aarg = zz; side_nxt.axis = AX_X; side_nxt.bad = 1'b1;
      end
    endcase
    piv_abs = (piv < 0) ? 17'(-piv) : 17'(piv);
    reg_br  = piv_abs < {2'b00, limit_r};

    // lo / hi lanes are the two non-pivot axes in x, y, z order
    unique case (code_r)
      3'd0: begin
        side_nxt.lo = reg_br ? prerot(-e23, e33) : prerot(e32, e22);
        side_nxt.hi = reg_br ? prerot(-e12, e11) : prerot(zz, zz);
      end
      3'd1: begin
        side_nxt.lo = reg_br ? prerot(-e23, e22) : prerot(zz, zz);
        side_nxt.hi = reg_br ? prerot(-e31, e11) : prerot(e13, e33);
      end
      3'd2: begin
        side_nxt.lo = reg_br ? prerot(-e31, e33) : prerot(zz, zz);
        side_nxt.hi = reg_br ? prerot(-e12, e22) : prerot(e21, e11);
      end
      3'd3: begin
        side_nxt.lo = reg_br ? prerot(e32, e22) : prerot(-e23, e33);
        side_nxt.hi = reg_br ? prerot(e13, e11) : prerot(zz, zz);
      end
      3'd4: begin
        side_nxt.lo = reg_br ? prerot(e13, e33) : prerot(-e31, e11);
        side_nxt.hi = reg_br ? prerot(e21, e22) : prerot(zz, zz);
      end
      3'd5: begin
        side_nxt.lo = reg_br ? prerot(e32, e33) : prerot(zz, zz);
        side_nxt.hi = reg_br ? prerot(e21, e11) : prerot(-e12, e22);
      end
      default: begin
        side_nxt.lo = prerot(zz, zz);
        side_nxt.hi = prerot(zz, zz);
      end
    endcase

    // clamp to +-1.0, then radicand (1 - p^2) scaled to Q.36
    if (aarg > 17'sd16384) begin
      p_cl = 16'sd16384;
    end else if (aarg < -17'sd16384) begin
      p_cl = -16'sd16384;
    end else begin
      p_cl = aarg[15:0];
    end
    side_nxt.p  = p_cl;
    pp          = 29'(32'(p_cl) * 32'(p_cl));
    sq_nxt.rem  = 21'd0;
    sq_nxt.root = 19'd0;
    sq_nxt.rad  = {1'b0, (29'h1000_0000 - pp), 8'h00};
  end

  // ---- root cell row ----
  sq_t   sq0_r;
  sq_t   sq_w [1:SQ_STAGES];
  side_t side_r [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    sq0_r     <= sq_nxt;
    side_r[0] <= side_nxt;
    for (int i = 1; i <= SQ_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
    if (g == 0) begin : g_first
      rmea_sqrt_cell u_cell (.clk(clk), .d(sq0_r), .q_r(sq_w[1]));
    end else begin : g_rest
      rmea_sqrt_cell u_cell (.clk(clk), .d(sq_w[g]), .q_r(sq_w[g+1]));
    end
  end

  // ---- CORDIC cell rows: lane 0 asin, lane 1 lo axis, lane 2 hi axis ----
  lane_t co_in [3];
  lane_t co_w  [3][1:CO_STAGES];
  meta_t meta_r [1:CO_STAGES];

  always_comb begin
    co_in[0].x    = signed'({3'b000, sq_w[SQ_STAGES].root, 12'h000});
    co_in[0].y    = signed'({{2{side_r[SQ_STAGES].p[15]}}, side_r[SQ_STAGES].p, 16'h0000});
    co_in[0].z    = 26'sd0;
    co_in[0].zero = 1'b0;
    co_in[1]      = side_r[SQ_STAGES].lo;
    co_in[2]      = side_r[SQ_STAGES].hi;
  end

  always_ff @(posedge clk) begin
    meta_r[1].axis <= side_r[SQ_STAGES].axis;
    meta_r[1].bad  <= side_r[SQ_STAGES].bad;
    for (int i = 2; i <= CO_STAGES; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
  end

  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    for (genvar s = 0; s < CO_STAGES; s++) begin : g_co
      if (s == 0) begin : g_first
        rmea_cordic_cell u_cell (
          .clk(clk), .stage(4'(s)), .d(co_in[ln]), .q_r(co_w[ln][1]));
      end else begin : g_rest
        rmea_cordic_cell u_cell (
          .clk(clk), .stage(4'(s)), .d(co_w[ln][s]), .q_r(co_w[ln][s+1]));
      end
    end
  end

  // ---- valid chain ----
  logic [VLD_LEN-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLD_LEN-2:0], in_vld_r};
    end
  end

  // ---- round to 1/128 degree, clamp, route lanes to axes ----
  logic signed [15:0] ang [3];
  logic signed [25:0] zf;
  logic signed [25:0] zr;
  logic signed [16:0] zs;
  logic signed [15:0] ax_nxt, ay_nxt, az_nxt;
  meta_t              mt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      zf = co_w[l][CO_STAGES].zero ? 26'sd0 : co_w[l][CO_STAGES].z;
      zr = zf + 26'sd256;
      zs = zr[25:9];
      if (zs > 17'sd23040) begin
        ang[l] = 16'sd23040;
      end else if (zs < -17'sd23040) begin
        ang[l] = -16'sd23040;
      end else begin
        ang[l] = zs[15:0];
      end
    end
    mt = meta_r[CO_STAGES];
    unique case (mt.axis)
      AX_X: begin ax_nxt = ang[0]; ay_nxt = ang[1]; az_nxt = ang[2]; end
      AX_Y: begin ax_nxt = ang[1]; ay_nxt = ang[0]; az_nxt = ang[2]; end
      default: begin ax_nxt = ang[1]; ay_nxt = ang[2]; az_nxt = ang[0]; end
    endcase
    if (mt.bad) begin
      ax_nxt = 16'sd0; ay_nxt = 16'sd0; az_nxt = 16'sd0;
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[VLD_LEN-1];
    end
  end

  logic signed [15:0] ax_r, ay_r, az_r;
  logic               bad_r;
  always_ff @(posedge clk) begin
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    az_r  <= az_nxt;
    bad_r <= mt.bad;
  end

  assign out_valid     = out_valid_r;
  assign out_angle_x   = ax_r;
  assign out_angle_y   = ay_r;
  assign out_angle_z   = az_r;
  assign out_bad_order = bad_r;

  // ---- checks ----
  // a result beat must trace back to the start that entered the pipeline for it
  `RMEA_ASSERT_IMP(a_lat, out_valid, $past(start, 38), "result beat without a start")
  `RMEA_ASSERT_IMP(a_bad_zero, out_valid && out_bad_order, (out_angle_x == 16'sd0) && (out_angle_y == 16'sd0) && (out_angle_z == 16'sd0), "bad order with nonzero angle")
  `RMEA_ASSERT_IMP(a_range, out_valid, (out_angle_x <= 16'sd23040) && (out_angle_x >= -16'sd23040) && (out_angle_z <= 16'sd23040) && (out_angle_z >= -16'sd23040), "angle out of range")

endmodule

`default_nettype wire
